// File: hdl/swa_pkg.sv
// Package for the sliding window average core.
// Holds the controller state type, the command/status structs and fixed widths.
// No dependencies.
`default_nettype none

package swa_pkg;

  localparam int unsigned WS_W   = 6;   // window size register
  localparam int unsigned OUT_W  = 24;  // average, Q8
  localparam int unsigned FRAC_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } swa_state_e;

  typedef struct packed {
    logic accept;    // take the input beat, read oldest ring slot
    logic update;    // write ring, update sum / fill / pointer
    logic div_load;  // load divider from new sum
    logic div_step;  // one restoring divide step
    logic out_load;  // move quotient into output register
  } swa_cmd_t;

  typedef struct packed {
    logic emit;      // window full after this sample
    logic div_done;
    logic out_free;  // output register empty or being drained
  } swa_status_t;

endpackage

`default_nettype wire

// File: hdl/sliding_window_average_core.sv
// Boxcar moving average of signed samples, mean in Q8, truncated toward zero.
// Per beat: accept, ring update, and once the window is full a restoring
//   divide and output load, which waits while the output is still held.
// A new beat is taken only after the previous one is done; the divider is
//   bit-serial (one quotient bit per cycle).
// Reset: async active low; window size 1, sum/fill/pointer zero, ring undefined.
`default_nettype none

module sliding_window_average_core #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [swa_pkg::WS_W-1:0]           cfg_wdata_i,   // window_size
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata_i, // [SAMPLE_BITS-1:0] sample
  input  wire                                s_axis_tuser_i, // start_of_series
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  output logic [swa_pkg::OUT_W-1:0]          m_axis_tdata_o  // [23:0] average_q8
);
  import swa_pkg::*;

  swa_cmd_t    cmd;
  swa_status_t status;

  swa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swa_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .start_i     (s_axis_tuser_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// File: hdl/swa_ctrl.sv
// Controller FSM for the sliding window average core.
// Sequences accept, update, divide and output load. Depends on swa_pkg.
`default_nettype none

module swa_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  swa_pkg::swa_status_t status_i,
  output swa_pkg::swa_cmd_t    cmd_o
);
  import swa_pkg::*;

  swa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = status_i.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_UPD: begin
        cmd_o.update   = 1'b1;
        cmd_o.div_load = status_i.emit;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_OUT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/swa_dp.sv
// Datapath for the sliding window average core: sample ring, running sum,
// fill count, bit-serial divider and output register. Depends on swa_pkg.
`default_nettype none

module swa_dp #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [swa_pkg::WS_W-1:0]     cfg_wdata_i,
  input  wire  [SAMPLE_BITS-1:0]       sample_i,
  input  wire                          start_i,
  input  swa_pkg::swa_cmd_t            cmd_i,
  output swa_pkg::swa_status_t         status_o,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [swa_pkg::OUT_W-1:0]    out_data_o
);
  import swa_pkg::*;

  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
  localparam int unsigned IW    = (PTR_W + 1 > WS_W) ? PTR_W + 1 : WS_W;
  localparam int unsigned SUM_W = SAMPLE_BITS + PTR_W;
  localparam int unsigned N     = SUM_W + FRAC_W;
  localparam int unsigned CNT_W = $clog2(N + 1);
  localparam int unsigned QX_W  = ((N > OUT_W) ? N : OUT_W) + 1;

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

  logic [WS_W-1:0]        ws_q;
  logic [IW-1:0]          fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [PTR_W-1:0]       wp_q;
  logic [SAMPLE_BITS-1:0] smp_q, rd_q;
  logic [N-1:0]           dvd_q;
  logic [WS_W-1:0]        rem_q, dvs_q;
  logic                   neg_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_q, res;

  logic [IW-1:0]    eff_w;
  logic [IW-1:0]    wp_x, old_x;
  logic [PTR_W-1:0] old_addr, wp_inc;
  logic             full;
  logic [SUM_W-1:0] smp_x, old_sx, mag;
  logic [WS_W:0]    rem_sh, trial;
  logic             ge;
  logic [QX_W-1:0]  qx;

  // effective window: zero reads as one, clipped at MAX_WINDOW
  always_comb begin
    if (ws_q == '0) begin
      eff_w = IW'(1);
    end else if (IW'(ws_q) > IW'(MAX_WINDOW)) begin
      eff_w = IW'(MAX_WINDOW);
    end else begin
      eff_w = IW'(ws_q);
    end
  end

  always_comb begin
    wp_x = IW'(wp_q);
    if (wp_x >= eff_w) begin
      old_x = wp_x - eff_w;
    end else begin
      old_x = wp_x + IW'(MAX_WINDOW) - eff_w;
    end
    old_addr = old_x[PTR_W-1:0];
    wp_inc   = (wp_x == IW'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
  end

  always_comb begin
    full   = (fill_q >= eff_w);
    smp_x  = {{(SUM_W-SAMPLE_BITS){smp_q[SAMPLE_BITS-1]}}, smp_q};
    old_sx = full ? {{(SUM_W-SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q} : '0;
    sum_d  = sum_q - old_sx + smp_x;
    fill_d = full ? fill_q : fill_q + IW'(1);
    mag    = sum_d[SUM_W-1] ? (~sum_d + SUM_W'(1)) : sum_d;
  end

  // restoring divide step, quotient bits shift into the dividend register
  always_comb begin
    rem_sh = {rem_q, dvd_q[N-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    ge     = ~trial[WS_W];
  end

  // sign restore and saturation to the output range
  always_comb begin
    qx = QX_W'(dvd_q);
    if (neg_q) begin
      if (qx > QX_W'(2 ** (OUT_W - 1))) begin
        res = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        res = ~qx[OUT_W-1:0] + OUT_W'(1);
      end
    end else begin
      if (qx > QX_W'(2 ** (OUT_W - 1) - 1)) begin
        res = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        res = qx[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q <= sample_i;
      rd_q  <= ring[old_addr];
    end
    if (cmd_i.update) begin
      ring[wp_q] <= smp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dvd_q <= {mag, {FRAC_W{1'b0}}};
      rem_q <= '0;
      dvs_q <= WS_W'(eff_w);
      neg_q <= sum_d[SUM_W-1];
    end else if (cmd_i.div_step && cnt_q != '0) begin
      dvd_q <= {dvd_q[N-2:0], ge};
      rem_q <= ge ? trial[WS_W-1:0] : rem_sh[WS_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WS_W'(1);
      fill_q      <= '0;
      sum_q       <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ws_q   <= cfg_wdata_i;
        fill_q <= '0;
        sum_q  <= '0;
      end else if (cmd_i.accept && start_i) begin
        fill_q <= '0;
        sum_q  <= '0;
      end else if (cmd_i.update) begin
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
      if (cmd_i.update) begin
        wp_q <= wp_inc;
      end
      if (cmd_i.div_load) begin
        cnt_q <= CNT_W'(N);
      end else if (cmd_i.div_step && cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.emit     = (fill_d >= eff_w);
    status_o.div_done = (cnt_q == '0);
    status_o.out_free = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
